FILE: hw/rtl/spc_pkg.sv
// shared types, codes and sizes for the sequence precedence closure block
package spc_pkg;

  localparam int MAX_NODES    = 64;
  localparam int NODE_IW      = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int NODE_COUNT_W = 7;
  localparam int NODE_ID_W    = 7;
  localparam int OP_W         = 2;
  localparam int ROW_INDEX_W  = 6;
  localparam int ROW_BITS_W   = 64;
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_TDATA_W  = 72;
  localparam int CFG_ADDR_W   = 1;
  localparam int CFG_DATA_W   = 7;

  // operation codes
  localparam logic [OP_W-1:0] OP_ELEMENT = 2'd0;
  localparam logic [OP_W-1:0] OP_END_SEQ = 2'd1;
  localparam logic [OP_W-1:0] OP_FINISH  = 2'd2;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_NODE_COUNT = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DIRECTION  = 1'd1;

  // cell commands
  localparam int CELL_CMD_W = 3;
  localparam logic [CELL_CMD_W-1:0] CELL_HOLD      = 3'd0;
  localparam logic [CELL_CMD_W-1:0] CELL_LOAD      = 3'd1;
  localparam logic [CELL_CMD_W-1:0] CELL_MASK      = 3'd2;
  localparam logic [CELL_CMD_W-1:0] CELL_CLOSE     = 3'd3;
  localparam logic [CELL_CMD_W-1:0] CELL_SHIFT_ROW = 3'd4;
  localparam logic [CELL_CMD_W-1:0] CELL_SHIFT_COL = 3'd5;

  typedef logic [MAX_NODES-1:0] row_vec_t;

  typedef struct packed {
    logic [CELL_CMD_W-1:0] cmd;
    row_vec_t              load_bit;
    row_vec_t              mask;
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/spc_cell.sv
// one matrix row cell: load, mask, closure step with rotation, and emit shifts
module spc_cell
  import spc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  logic       seen_i,
  input  logic       keep_i,
  input  row_vec_t   head_row,
  input  row_vec_t   nbr_row,
  output row_vec_t   row_o
);

  row_vec_t row_r;
  row_vec_t row_nxt;
  row_vec_t merged;

  // pivot column always sits at bit 0 since every row rotates once per step
  assign merged = nbr_row[0] ? (nbr_row | head_row) : nbr_row;

  always_comb begin
    row_nxt = row_r;
    unique case (ctrl.cmd)
      CELL_HOLD:      row_nxt = row_r;
      CELL_LOAD:      row_nxt = seen_i ? (row_r | ctrl.load_bit) : row_r;
      CELL_MASK:      row_nxt = keep_i ? (row_r & ctrl.mask) : '0;
      CELL_CLOSE:     row_nxt = {merged[0], merged[MAX_NODES-1:1]};
      CELL_SHIFT_ROW: row_nxt = nbr_row;
      CELL_SHIFT_COL: row_nxt = row_r >> 1;
      default:        row_nxt = row_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else begin
      row_r <= row_nxt;
    end
  end

  assign row_o = row_r;

endmodule

FILE: hw/rtl/sequence_precedence_closure.sv
// top level: sequence loader, row cell chain, closure sequencer and row output
//
//  channel | handshake              | payload
//  in      | in_tvalid / in_tready  | tuser operation, tdata node_id
//  out     | out_tvalid / out_tready| tdata row_index, row_bits; tlast last_row
//  cfg     | cfg_wr_en              | cfg_addr, cfg_wdata
//
// element and end-of-sequence words are accepted back to back while idle.
// a finish word starts a mask step, then closure steps in which the rows rotate
// once around the cell ring, then emits one row per cycle while out_tready allows.
// input is held off from finish until the last row sits in the output register.
// synchronous active-low reset clears the matrix, the seen set, the sequencer and out_tvalid.
module sequence_precedence_closure
  import spc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [6:0] node_id, [7] zero
  input  logic [OP_W-1:0]        in_tuser,   // [1:0] operation
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [5:0] row_index, [69:6] row_bits, [71:70] zero
  output logic                   out_tlast,
  input  logic                   cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MASK  = 2'd1;
  localparam logic [1:0] S_CLOSE = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]              state_r, state_nxt;
  logic [NODE_COUNT_W-1:0] node_count_r;
  logic                    dir_r;
  row_vec_t                seen_r, seen_nxt;
  logic [NODE_IW-1:0]      step_r, step_nxt;
  logic [NODE_IW-1:0]      row_r, row_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0]  out_data_r, out_data_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [NODE_COUNT_W-1:0] n_eff;
  row_vec_t                use_mask;
  logic                    in_fire;
  logic [NODE_ID_W-1:0]    node_id;
  logic [NODE_ID_W-1:0]    id_m1;
  logic                    id_ok;
  logic                    out_free;
  logic                    last_row;
  cell_ctrl_t              ctrl;
  row_vec_t                rows   [MAX_NODES];
  row_vec_t                col_bits;
  row_vec_t                tail_nbr;
  row_vec_t                emit_row;

  always_comb begin
    if (node_count_r == '0) begin
      n_eff = NODE_COUNT_W'(1);
    end else if (node_count_r > NODE_COUNT_W'(MAX_NODES)) begin
      n_eff = NODE_COUNT_W'(MAX_NODES);
    end else begin
      n_eff = node_count_r;
    end
  end

  assign use_mask = ~({MAX_NODES{1'b1}} << n_eff);
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign node_id   = in_tdata[NODE_ID_W-1:0];
  assign id_m1     = node_id - NODE_ID_W'(1);
  assign id_ok     = (node_id != '0) && (node_id <= n_eff);
  assign out_free  = !out_valid_r || out_tready;
  assign last_row  = (NODE_COUNT_W'(row_r) + NODE_COUNT_W'(1)) == n_eff;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_W'(MAX_NODES);
      dir_r        <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_NODE_COUNT: node_count_r <= cfg_wdata[NODE_COUNT_W-1:0];
        REG_DIRECTION:  dir_r        <= cfg_wdata[0];
        default:        ;
      endcase
    end
  end

  // cell chain
  assign tail_nbr = (ctrl.cmd == CELL_CLOSE) ? rows[0] : '0;

  for (genvar i = 0; i < MAX_NODES; i++) begin : g_cell
    row_vec_t nbr;
    if (i == MAX_NODES - 1) begin : g_tail
      assign nbr = tail_nbr;
    end else begin : g_mid
      assign nbr = rows[i+1];
    end
    assign col_bits[i] = rows[i][0];
    spc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .seen_i   (seen_r[i]),
      .keep_i   (NODE_COUNT_W'(i) < n_eff),
      .head_row (rows[0]),
      .nbr_row  (nbr),
      .row_o    (rows[i])
    );
  end

  assign emit_row = dir_r ? col_bits : rows[0];

  always_comb begin
    state_nxt     = state_r;
    seen_nxt      = seen_r;
    step_nxt      = step_r;
    row_nxt       = row_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    ctrl.cmd      = CELL_HOLD;
    ctrl.load_bit = row_vec_t'(1) << id_m1;
    ctrl.mask     = use_mask;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_tuser)
            OP_ELEMENT: begin
              if (id_ok) begin
                ctrl.cmd = CELL_LOAD;
                seen_nxt = seen_r | ctrl.load_bit;
              end
            end
            OP_END_SEQ: seen_nxt = '0;
            OP_FINISH: begin
              seen_nxt  = '0;
              state_nxt = S_MASK;
            end
            default: ;
          endcase
        end
      end
      S_MASK: begin
        ctrl.cmd  = CELL_MASK;
        step_nxt  = '0;
        state_nxt = S_CLOSE;
      end
      S_CLOSE: begin
        ctrl.cmd = CELL_CLOSE;
        step_nxt = step_r + NODE_IW'(1);
        if (step_r == NODE_IW'(MAX_NODES - 1)) begin
          row_nxt   = '0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ctrl.cmd      = dir_r ? CELL_SHIFT_COL : CELL_SHIFT_ROW;
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{(OUT_TDATA_W - ROW_BITS_W - ROW_INDEX_W){1'b0}},
                           ROW_BITS_W'(emit_row), ROW_INDEX_W'(row_r)};
          out_last_nxt  = last_row;
          row_nxt       = row_r + NODE_IW'(1);
          if (last_row) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seen_r      <= '0;
      step_r      <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seen_r      <= seen_nxt;
      step_r      <= step_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: hw/rtl/spc_checker.sv
// port-level checks for the sequence precedence closure block, bound to the top
module spc_checker
  import spc_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [OP_W-1:0]        in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

  // block is ready right after reset
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("not ready after reset");

  // finish starts the closure and holds off input
  a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_FINISH) |=> !in_tready)
    else $error("input taken during closure");

  // a pending non-final row means emission is still running
  a_row_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input ready in the middle of emission");

  // when the final row shows up the block is back to loading
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid && out_tlast) |-> in_tready)
    else $error("not ready after final row");

endmodule

bind sequence_precedence_closure spc_checker u_spc_checker (.*);

FILE: sim/sequence_precedence_closure_test.sv
// testbench for the sequence precedence closure block: row scoreboard, word drivers and checks
module sequence_precedence_closure_test
  import spc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_WORDS     = 320;
  localparam int SETTLE_CYCLES    = 8;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT      = 400000;

  typedef struct packed {
    logic [ROW_INDEX_W-1:0] index;
    row_vec_t               bits;
    logic                   last;
  } closure_row_t;

  class closure_scoreboard;
    row_vec_t                follows [MAX_NODES];
    row_vec_t                seen;
    logic [NODE_COUNT_W-1:0] count_reg;
    logic                    dir_reg;
    closure_row_t            rows_due [$];
    int                      errors;
    int                      rows_checked;
    int                      words_noted;

    function new();
      foreach (follows[i]) follows[i] = '0;
      seen         = '0;
      count_reg    = NODE_COUNT_W'(MAX_NODES);
      dir_reg      = 1'b0;
      errors       = 0;
      rows_checked = 0;
      words_noted  = 0;
    endfunction

    function int active_count();
      if (count_reg == 0) return 1;
      if (count_reg > MAX_NODES) return MAX_NODES;
      return int'(count_reg);
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      if (addr == REG_NODE_COUNT) count_reg = data[NODE_COUNT_W-1:0];
      else if (addr == REG_DIRECTION) dir_reg = data[0];
    endfunction

    function void note_word(logic [OP_W-1:0] op, logic [NODE_ID_W-1:0] id);
      int           n, i, k;
      row_vec_t     mask, id_bit, r;
      row_vec_t     work [MAX_NODES];
      closure_row_t row;
      n = active_count();
      mask = (n >= MAX_NODES) ? '1 : ((row_vec_t'(1) << n) - row_vec_t'(1));
      words_noted++;
      case (op)
        OP_ELEMENT: begin
          if (id >= 1 && id <= n) begin
            id_bit = row_vec_t'(1) << (id - 1);
            for (i = 0; i < MAX_NODES; i++) begin
              if (seen[i]) follows[i] |= id_bit;
            end
            seen |= id_bit;
          end
        end
        OP_END_SEQ: seen = '0;
        OP_FINISH: begin
          // nodes at or above the count take no part in any path
          for (i = 0; i < MAX_NODES; i++) work[i] = (i < n) ? (follows[i] & mask) : '0;
          for (k = 0; k < n; k++) begin
            for (i = 0; i < n; i++) begin
              if (work[i][k]) work[i] |= work[k];
            end
          end
          for (i = 0; i < n; i++) begin
            if (dir_reg) begin
              r = '0;
              for (k = 0; k < n; k++) r[k] = work[k][i];
            end else begin
              r = work[i];
            end
            row.index = ROW_INDEX_W'(i);
            row.bits  = r;
            row.last  = (i == n - 1);
            rows_due.push_back(row);
          end
          foreach (follows[j]) follows[j] = '0;
          seen = '0;
        end
        default: ;
      endcase
    endfunction

    function void check_row(logic [ROW_INDEX_W-1:0] index, row_vec_t bits, logic last);
      closure_row_t want;
      if (rows_due.size() == 0) begin
        $error("row %0d arrived with no row expected", index);
        errors++;
        return;
      end
      want = rows_due.pop_front();
      rows_checked++;
      if (index !== want.index) begin
        $error("row_index: expected %0d, actual %0d", want.index, index);
        errors++;
      end
      if (bits !== want.bits) begin
        $error("row_bits: expected %h, actual %h", want.bits, bits);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_row: expected %0d, actual %0d", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // [6:0] node_id, [7] zero
  logic [OP_W-1:0]        in_tuser   = '0;   // [1:0] operation
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // [5:0] row_index, [69:6] row_bits, [71:70] zero
  logic                   out_tlast;
  logic                   cfg_wr_en  = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  closure_scoreboard sb = new();
  int   send_quiet     = 0;
  int   sink_quiet     = 0;
  int   settings_used  = 0;
  logic hold_request   = 1'b0;
  logic hold_done      = 1'b0;

  sequence_precedence_closure dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // random gap per word, with occasional runs of back-to-back words
  function automatic int idle_cycles(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      quiet = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  task automatic send_word(input logic [OP_W-1:0] op, input logic [NODE_ID_W-1:0] id);
    int gap;
    gap = idle_cycles(send_quiet);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_TDATA_W'(id);
    do @(posedge clk); while (!in_tready);
    sb.note_word(op, id);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.rows_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(input logic [NODE_COUNT_W-1:0] count, input logic dir);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= REG_NODE_COUNT;
    cfg_wdata <= CFG_DATA_W'(count);
    @(posedge clk);
    sb.write_reg(REG_NODE_COUNT, CFG_DATA_W'(count));
    cfg_addr  <= REG_DIRECTION;
    cfg_wdata <= CFG_DATA_W'(dir);
    @(posedge clk);
    sb.write_reg(REG_DIRECTION, CFG_DATA_W'(dir));
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // a few sequences with random ids, mostly in range, then optionally the finish
  task automatic load_set(input logic with_finish, input logic may_hold, inout int counted);
    int                   seqs, len, s, e, n;
    logic [NODE_ID_W-1:0] id;
    n = sb.active_count();
    seqs = $urandom_range(1, 4);
    for (s = 0; s < seqs; s++) begin
      len = $urandom_range(1, 8);
      for (e = 0; e < len; e++) begin
        if ($urandom_range(0, 9) == 0) send_word(OP_UNUSED, NODE_ID_W'($urandom));
        if ($urandom_range(0, 6) == 0) begin
          // stray ids: zero, just past the count, or anything in the field
          case ($urandom_range(0, 2))
            0:       id = '0;
            1:       id = NODE_ID_W'(n + 1);
            default: id = NODE_ID_W'($urandom);
          endcase
        end else begin
          id = NODE_ID_W'($urandom_range(1, n));
        end
        send_word(OP_ELEMENT, id);
        if (id >= 1 && id <= n) counted++;
      end
      if ($urandom_range(0, 4) != 0) begin
        send_word(OP_END_SEQ, NODE_ID_W'($urandom));
        counted++;
      end
    end
    if (with_finish) begin
      if (may_hold && !hold_done && counted > 40) begin
        hold_request = 1'b1;
        hold_done    = 1'b1;
      end
      send_word(OP_FINISH, NODE_ID_W'($urandom));
      counted++;
    end
  endtask

  initial begin : row_sink
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        stall        = LONG_HOLD_CYCLES;
        hold_request = 1'b0;
      end else begin
        stall = idle_cycles(sink_quiet);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_row(out_tdata[ROW_INDEX_W-1:0], out_tdata[ROW_INDEX_W +: ROW_BITS_W], out_tlast);
    end
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sequence_precedence_closure: mismatch");
    $finish;
  end

  initial begin : stimulus
    int                      counted, sets, s, pick;
    logic [NODE_COUNT_W-1:0] count;
    counted = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: repeated node, id zero, an unused code
    send_word(OP_ELEMENT, 7'd1);
    send_word(OP_ELEMENT, 7'd64);
    send_word(OP_ELEMENT, 7'd1);
    send_word(OP_ELEMENT, 7'd0);
    send_word(OP_UNUSED, 7'd127);
    send_word(OP_END_SEQ, 7'd0);
    send_word(OP_ELEMENT, 7'd64);
    send_word(OP_FINISH, 7'd0);
    drain_results();

    // before relation, finish while a sequence is still open
    set_regs(7'd5, 1'b1);
    send_word(OP_ELEMENT, 7'd3);
    send_word(OP_ELEMENT, 7'd1);
    send_word(OP_END_SEQ, 7'd0);
    send_word(OP_ELEMENT, 7'd1);
    send_word(OP_ELEMENT, 7'd5);
    send_word(OP_ELEMENT, 7'd2);
    send_word(OP_FINISH, 7'd0);

    // node 4 is loaded, then the count drops below it before the finish
    send_word(OP_ELEMENT, 7'd2);
    send_word(OP_ELEMENT, 7'd4);
    drain_results();
    set_regs(7'd3, 1'b0);
    send_word(OP_FINISH, 7'd0);
    drain_results();

    // zero count behaves as one node
    set_regs(7'd0, 1'b1);
    send_word(OP_ELEMENT, 7'd1);
    send_word(OP_ELEMENT, 7'd1);
    send_word(OP_ELEMENT, 7'd2);
    send_word(OP_FINISH, 7'd0);
    drain_results();

    // count above the matrix size is clamped
    set_regs(7'd127, 1'b0);
    send_word(OP_ELEMENT, 7'd63);
    send_word(OP_ELEMENT, 7'd100);
    send_word(OP_ELEMENT, 7'd64);
    send_word(OP_FINISH, 7'd0);

    while (sb.words_noted < RANDOM_WORDS) begin
      drain_results();
      pick = $urandom_range(0, 19);
      if (pick < 12) count = NODE_COUNT_W'($urandom_range(1, 12));
      else if (pick < 16) count = NODE_COUNT_W'($urandom_range(13, 64));
      else if (pick == 16) count = '0;
      else if (pick == 17) count = NODE_COUNT_W'(MAX_NODES);
      else count = NODE_COUNT_W'($urandom_range(65, 127));
      set_regs(count, 1'($urandom_range(0, 1)));
      sets = $urandom_range(1, 3);
      for (s = 0; s < sets; s++) load_set(1'b1, s < sets - 1, counted);
      // sometimes leave a set open across the next register change
      if ($urandom_range(0, 3) == 0) load_set(1'b0, 1'b0, counted);
    end
    drain_results();

    $display("covered %0d input words and %0d closure rows over %0d register settings",
             sb.words_noted, sb.rows_checked, settings_used);
    if (sb.errors == 0 && sb.rows_due.size() == 0) begin
      $display("sequence_precedence_closure: match");
    end else begin
      $display("sequence_precedence_closure: mismatch");
    end
    $finish;
  end

endmodule
